// File: hdl/id_pool_allocator_top_assert.svh
// Assertion macros shared by the id pool allocator.
`ifndef ID_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define ID_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define IPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id pool allocator assertion failed");

// Implication with a fixed delay in cycles.
`define IPA_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("id pool allocator assertion failed");

`endif

// File: hdl/ipa_pkg.sv
`default_nettype none

package ipa_pkg;

    // Widest pool index and count over the supported pool sizes (up to 1024).
    localparam int IDX_MAX_W = 10;
    localparam int CNT_MAX_W = 11;

    typedef enum logic [1:0] {
        FN_RESERVE = 2'd0,
        FN_RETIRE  = 2'd1,
        FN_RESTORE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_USED    = 2'd1,
        ST_RETIRED = 2'd2
    } id_state_t;

    typedef struct packed {
        logic                 pop;
        logic                 push;
        logic [IDX_MAX_W-1:0] push_idx;
    } fifo_ctl_t;

    typedef struct packed {
        logic [IDX_MAX_W-1:0] head_idx;
        logic [IDX_MAX_W-1:0] head_ptr;
        logic                 head_wrap;
        logic [CNT_MAX_W-1:0] count;
    } fifo_stat_t;

    typedef struct packed {
        logic                 we;
        logic [IDX_MAX_W-1:0] addr;
        id_state_t            data;
    } stat_wr_t;

endpackage

`default_nettype wire

// File: hdl/ipa_free_fifo.sv
`default_nettype none

module ipa_free_fifo #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  ipa_pkg::fifo_ctl_t      ctl,
    output ipa_pkg::fifo_stat_t     stat
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

    logic [IW-1:0] mem [POOL_SIZE];

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          hwrap_reg, hwrap_next;
    logic          twrap_reg, twrap_next;
    logic [CW-1:0] count_reg, count_next;

    logic [IW-1:0] q_reg;
    logic          byp_reg;
    logic [IW-1:0] byp_val_reg;

    logic [IW-1:0] push_idx;
    logic          written;
    logic [IW-1:0] head_val;

    assign push_idx = ctl.push_idx[IW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        hwrap_next = hwrap_reg;
        twrap_next = twrap_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + IW'(1);
            hwrap_next = hwrap_reg | (head_reg == LAST);
            count_next = count_reg - CW'(1);
        end
        else if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + IW'(1);
            twrap_next = twrap_reg | (tail_reg == LAST);
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            hwrap_reg <= 1'b0;
            twrap_reg <= 1'b0;
            count_reg <= CW'(POOL_SIZE);
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            hwrap_reg <= hwrap_next;
            twrap_reg <= twrap_next;
            count_reg <= count_next;
            byp_reg   <= ctl.push && (tail_reg == head_next);
        end
    end

    // Prefetch the entry at the next head every cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_idx;
        end
        q_reg       <= mem[head_next];
        byp_val_reg <= push_idx;
    end

    // A slot the tail has never reached still holds its own index.
    assign written  = twrap_reg || (head_reg < tail_reg);
    assign head_val = byp_reg ? byp_val_reg : (written ? q_reg : head_reg);

    always_comb
    begin
        stat.head_idx  = ipa_pkg::IDX_MAX_W'(head_val);
        stat.head_ptr  = ipa_pkg::IDX_MAX_W'(head_reg);
        stat.head_wrap = hwrap_reg;
        stat.count     = ipa_pkg::CNT_MAX_W'(count_reg);
    end

endmodule

`default_nettype wire

// File: hdl/ipa_status_ram.sv
`default_nettype none

module ipa_status_ram #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(POOL_SIZE)-1:0] rd_addr,
    input  ipa_pkg::stat_wr_t               wr,
    input  ipa_pkg::fifo_stat_t             fstat,
    output ipa_pkg::id_state_t              state
);

    localparam int IW = $clog2(POOL_SIZE);

    logic [1:0] mem [POOL_SIZE];

    logic [IW-1:0]      wr_addr;
    logic [1:0]         q_reg;
    logic [IW-1:0]      rd_addr_reg;
    logic               byp_reg;
    ipa_pkg::id_state_t byp_val_reg;
    logic               touched;

    assign wr_addr = wr.addr[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
            byp_val_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr.we && (wr_addr == rd_addr);
        end
    end

    // Only IDs the head has already passed were ever written.
    assign touched = fstat.head_wrap || (rd_addr_reg < fstat.head_ptr[IW-1:0]);

    always_comb
    begin
        if (byp_reg)
        begin
            state = byp_val_reg;
        end
        else if (touched)
        begin
            state = ipa_pkg::id_state_t'(q_reg);
        end
        else
        begin
            state = ipa_pkg::ST_FREE;
        end
    end

endmodule

`default_nettype wire

// File: hdl/id_pool_allocator_top.sv
`default_nettype none
// Timing: a taken request is registered in req_valid_reg, and its result strobe is registered from it in done_reg.
// Throughput: one request per cycle, sustained while busy is low; the free-list and status memories
// each take one write and one registered read per cycle, with bypass on collisions.
// Reset: all IDs free in ascending order, used total cleared, free count full, id_base zero; busy is high
// for the first cycle after reset release. The receiver cannot stall results.

`include "id_pool_allocator_top_assert.svh"

module id_pool_allocator_top #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] id_in,
    output logic             done,
    output logic             ok,
    output logic [15:0]      id_out,
    output logic [6:0]       free_count,
    output logic [6:0]       used_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic          busy_reg;
    logic [15:0]   id_base_reg;

    logic          accept;
    logic [15:0]   offset;
    logic          in_pool;
    logic [IW-1:0] rd_addr;

    logic          req_valid_reg;
    logic [1:0]    func_reg;
    logic [IW-1:0] idx_reg;
    logic          inpool_reg;

    logic [CW-1:0] used_total_reg, used_total_next;

    ipa_pkg::fifo_ctl_t  fctl;
    ipa_pkg::fifo_stat_t fstat;
    ipa_pkg::stat_wr_t   swr;
    ipa_pkg::id_state_t  st_val;

    logic [CW-1:0] free_cnt;
    logic [IW-1:0] head_idx;
    logic          ok_next;
    logic [15:0]   id_next;
    logic          pop;
    logic          push;
    logic          we;
    logic [IW-1:0] wr_addr;
    ipa_pkg::id_state_t wr_data;
    logic [CW-1:0] free_after;
    logic [XW-1:0] free_x;
    logic [XW-1:0] used_x;
    logic [CW:0]   pool_sum;

    logic          done_reg;
    logic          ok_reg;
    logic [15:0]   id_out_reg;
    logic [6:0]    free_out_reg;
    logic [6:0]    used_out_reg;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    assign offset  = id_in - id_base_reg;
    assign in_pool = offset < 16'(POOL_SIZE);
    assign rd_addr = offset[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            id_base_reg    <= '0;
            req_valid_reg  <= 1'b0;
            used_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            busy_reg       <= 1'b0;
            req_valid_reg  <= accept;
            used_total_reg <= used_total_next;
            done_reg       <= req_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                id_base_reg <= cfg_data;
            end
        end
    end

    // Hold the request for processing, and register the result outputs.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            idx_reg    <= rd_addr;
            inpool_reg <= in_pool;
        end
        ok_reg       <= ok_next;
        id_out_reg   <= id_next;
        free_out_reg <= free_x[6:0];
        used_out_reg <= used_x[6:0];
    end

    ipa_free_fifo #(
        .POOL_SIZE (POOL_SIZE)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .stat  (fstat)
    );

    ipa_status_ram #(
        .POOL_SIZE (POOL_SIZE)
    ) u_status (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (swr),
        .fstat   (fstat),
        .state   (st_val)
    );

    assign free_cnt = fstat.count[CW-1:0];
    assign head_idx = fstat.head_idx[IW-1:0];

    always_comb
    begin
        ok_next         = 1'b0;
        id_next         = '0;
        pop             = 1'b0;
        push            = 1'b0;
        we              = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = ipa_pkg::ST_FREE;
        used_total_next = used_total_reg;
        if (req_valid_reg)
        begin
            case (func_reg)
                ipa_pkg::FN_RESERVE:
                begin
                    if (free_cnt != '0)
                    begin
                        ok_next         = 1'b1;
                        pop             = 1'b1;
                        we              = 1'b1;
                        wr_addr         = head_idx;
                        wr_data         = ipa_pkg::ST_USED;
                        id_next         = id_base_reg + 16'(head_idx);
                        used_total_next = used_total_reg + CW'(1);
                    end
                end
                ipa_pkg::FN_RETIRE:
                begin
                    if (inpool_reg && (st_val == ipa_pkg::ST_USED))
                    begin
                        ok_next         = 1'b1;
                        we              = 1'b1;
                        wr_data         = ipa_pkg::ST_RETIRED;
                        used_total_next = used_total_reg - CW'(1);
                    end
                end
                ipa_pkg::FN_RESTORE:
                begin
                    if (inpool_reg && (st_val == ipa_pkg::ST_USED))
                    begin
                        ok_next         = 1'b1;
                        we              = 1'b1;
                        push            = 1'b1;
                        wr_data         = ipa_pkg::ST_FREE;
                        used_total_next = used_total_reg - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop)
        begin
            free_after = free_cnt - CW'(1);
        end
        else if (push)
        begin
            free_after = free_cnt + CW'(1);
        end
        else
        begin
            free_after = free_cnt;
        end
    end

    assign free_x = XW'(free_after);
    assign used_x = XW'(used_total_next);

    always_comb
    begin
        fctl.pop      = pop;
        fctl.push     = push;
        fctl.push_idx = ipa_pkg::IDX_MAX_W'(idx_reg);
        swr.we        = we;
        swr.addr      = ipa_pkg::IDX_MAX_W'(wr_addr);
        swr.data      = wr_data;
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign id_out     = id_out_reg;
    assign free_count = free_out_reg;
    assign used_count = used_out_reg;

    assign pool_sum = (CW + 1)'(free_cnt) + (CW + 1)'(used_total_reg);

    `IPA_ASSERT_DELAY(a_request_gives_result, clk, rst_n, accept, 2, done)
    `IPA_ASSERT_IMPL(a_counts_within_pool, clk, rst_n, 1'b1, pool_sum <= (CW + 1)'(POOL_SIZE))
    `IPA_ASSERT_IMPL(a_fail_gives_zero_id, clk, rst_n, done && !ok, id_out == 16'd0)

endmodule

`default_nettype wire
